// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers for the register file unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/rfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rfr_pkg;
	localparam int FIFO_DEPTH = 64;
	localparam int REG_COUNT  = 64;
	localparam int BURST_MAX  = 18;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int REG_AW     = $clog2(REG_COUNT);

	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_INIT = 16'h6363;
	localparam logic [7:0]  VERSION_VALUE = 8'h92;
	localparam logic [7:0]  CONTROL_RESET = 8'h80;
	localparam logic [7:0]  RX_IRQ = 8'h04;

	localparam logic [REG_AW-1:0] A_COMMAND   = REG_AW'(6'h01);
	localparam logic [REG_AW-1:0] A_COMIRQ    = REG_AW'(6'h04);
	localparam logic [REG_AW-1:0] A_DIVIRQ    = REG_AW'(6'h05);
	localparam logic [REG_AW-1:0] A_FIFODATA  = REG_AW'(6'h09);
	localparam logic [REG_AW-1:0] A_FIFOLEVEL = REG_AW'(6'h0A);
	localparam logic [REG_AW-1:0] A_CONTROL   = REG_AW'(6'h0C);
	localparam logic [REG_AW-1:0] A_CRC_H     = REG_AW'(6'h21);
	localparam logic [REG_AW-1:0] A_CRC_L     = REG_AW'(6'h22);
	localparam logic [REG_AW-1:0] A_VERSION   = REG_AW'(6'h37);

	localparam logic [7:0] CMD_SOFTRESET  = 8'h0F;
	localparam logic [7:0] CMD_TRANSCEIVE = 8'h0C;
	localparam logic [7:0] CMD_CALC_CRC   = 8'h03;

	localparam logic [7:0] PICC_REQA  = 8'h26;
	localparam logic [7:0] PICC_WUPA  = 8'h52;
	localparam logic [7:0] PICC_SEL1  = 8'h93;
	localparam logic [7:0] PICC_SEL2  = 8'h95;
	localparam logic [7:0] PICC_SEL3  = 8'h97;
	localparam logic [7:0] ATQA_LO    = 8'h04;
	localparam logic [7:0] ATQA_HI    = 8'h00;
	localparam logic [7:0] SAK_VALUE  = 8'h08;
	localparam logic [7:0] LEVEL_MASK = 8'h7F;

	localparam logic [31:0] UID_RESET = 32'h399D9250;

	typedef struct packed {
		logic              we;
		logic [REG_AW-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [REG_AW-1:0] raddr;
	} reg_req_t;

	typedef struct packed {
		logic               we;
		logic [FIFO_AW-1:0] waddr;
		logic [7:0]         wdata;
		logic               re;
		logic [FIFO_AW-1:0] raddr;
	} fifo_req_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             armed;
	} status_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int j = 0; j < 8; j++) begin
			if (c[0]) c = (c >> 1) ^ CRC_POLY;
			else c = c >> 1;
		end
		return c;
	endfunction

	localparam logic [15:0] CRC_SAK = crc_byte(CRC_INIT, SAK_VALUE);

	function automatic logic [7:0] reg_reset_val(input logic [REG_AW-1:0] a);
		if (a == A_CONTROL) return CONTROL_RESET;
		else if (a == A_VERSION) return VERSION_VALUE;
		else return 8'h00;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/rfr_reg_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rfr_reg_bank (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rfr_pkg::reg_req_t req,
	output logic [7:0]             rdata
);
	logic [7:0] mem_q [rfr_pkg::REG_COUNT];
	logic [rfr_pkg::REG_COUNT-1:0] vld_q;
	logic [7:0] rd_s1;
	logic vld_s1;
	logic [rfr_pkg::REG_AW-1:0] addr_s1;

	always_ff @(posedge clk) begin
		if (req.we) mem_q[req.waddr] <= req.wdata;
		if (req.re) begin
			rd_s1   <= mem_q[req.raddr];
			vld_s1  <= vld_q[req.raddr];
			addr_s1 <= req.raddr;
		end
	end

	// entries never written read as their reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.we) begin
			vld_q[req.waddr] <= 1'b1;
		end
	end

	assign rdata = vld_s1 ? rd_s1 : rfr_pkg::reg_reset_val(addr_s1);
endmodule
`default_nettype wire

// ===== rtl/rfr_fifo_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rfr_fifo_buf (
	input  wire logic               clk,
	input  wire rfr_pkg::fifo_req_t req,
	output logic [7:0]              rdata
);
	logic [7:0] mem_q [rfr_pkg::FIFO_DEPTH];
	logic [7:0] rd_s1;

	always_ff @(posedge clk) begin
		if (req.we) mem_q[req.waddr] <= req.wdata;
		if (req.re) rd_s1 <= mem_q[req.raddr];
	end

	assign rdata = rd_s1;
endmodule
`default_nettype wire

// ===== rtl/rfr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rfr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [31:0]         uid,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                kind,
	input  wire logic [5:0]          address,
	input  wire logic [7:0]          write_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [7:0]               read_data,
	output logic                     last,
	output rfr_pkg::reg_req_t        reg_req,
	input  wire logic [7:0]          reg_rdata,
	output rfr_pkg::fifo_req_t       fifo_req,
	input  wire logic [7:0]          fifo_rdata,
	output rfr_pkg::status_t         status
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ONE    = 4'd1;
	localparam logic [3:0] S_RREG   = 4'd2;
	localparam logic [3:0] S_BURST  = 4'd3;
	localparam logic [3:0] S_RMW_RD = 4'd4;
	localparam logic [3:0] S_RMW_WR = 4'd5;
	localparam logic [3:0] S_SOFT   = 4'd6;
	localparam logic [3:0] S_CARD   = 4'd7;
	localparam logic [3:0] S_REQ2   = 4'd8;
	localparam logic [3:0] S_SEL    = 4'd9;
	localparam logic [3:0] S_SEL1   = 4'd10;
	localparam logic [3:0] S_SEL2   = 4'd11;
	localparam logic [3:0] S_UID    = 4'd12;
	localparam logic [3:0] S_CRC    = 4'd13;
	localparam logic [3:0] S_CRC_WL = 4'd14;
	localparam logic [3:0] S_CRC_WH = 4'd15;

	localparam int CW = rfr_pkg::CNT_W;
	localparam int FW = rfr_pkg::FIFO_AW;

	logic [3:0] state_q, state_d;
	logic [CW-1:0] count_q, count_d, i_q, i_d, n_q, n_d;
	logic armed_q, armed_d;
	logic [7:0] head_q, head_d, res_q, res_d;
	logic [2:0] k_q, k_d;
	logic match_q, match_d, m;
	logic [15:0] crc_q, crc_d;
	logic [rfr_pkg::REG_AW-1:0] rmw_addr_q, rmw_addr_d;
	logic rmw_set_q, rmw_set_d;
	logic out_valid_q, last_q, out_ld, out_lst;
	logic [7:0] read_data_q, out_dat, uid_k, uid_x;
	logic slot_free, accept;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign uid_k     = uid[8*k_q[1:0] +: 8];
	assign uid_x     = uid[7:0] ^ uid[15:8] ^ uid[23:16] ^ uid[31:24];
	assign m         = match_q && (fifo_rdata == uid_k);

	always_comb begin
		state_d = state_q; count_d = count_q; i_d = i_q; n_d = n_q;
		armed_d = armed_q; head_d = head_q; res_d = res_q; k_d = k_q;
		match_d = match_q; crc_d = crc_q; rmw_addr_d = rmw_addr_q;
		rmw_set_d = rmw_set_q;
		reg_req = '0; fifo_req = '0;
		out_ld = 1'b0; out_dat = 8'h00; out_lst = 1'b1;
		unique case (state_q)
			S_IDLE: if (accept) begin
				if (!kind) begin
					if (address == rfr_pkg::A_VERSION) begin
						res_d = rfr_pkg::VERSION_VALUE; state_d = S_ONE;
					end else if (address == rfr_pkg::A_FIFOLEVEL) begin
						res_d = 8'(count_q); state_d = S_ONE;
					end else if (address == rfr_pkg::A_FIFODATA) begin
						if (count_q == '0) begin
							res_d = 8'h00; state_d = S_ONE;
						end else begin
							n_d = (32'(count_q) > rfr_pkg::BURST_MAX) ?
								CW'(rfr_pkg::BURST_MAX) : count_q;
							i_d = '0;
							fifo_req.re = 1'b1; fifo_req.raddr = '0;
							state_d = S_BURST;
						end
					end else begin
						reg_req.re = 1'b1; reg_req.raddr = address;
						state_d = S_RREG;
					end
				end else if (address == rfr_pkg::A_FIFODATA) begin
					if (32'(count_q) < rfr_pkg::FIFO_DEPTH) begin
						fifo_req.we = 1'b1;
						fifo_req.waddr = FW'(count_q);
						fifo_req.wdata = write_data;
						if (count_q == '0) head_d = write_data;
						count_d = count_q + 1'b1;
						// ninth byte of an armed SEL1 select runs the card command
						if (count_q == CW'(8) && head_q == rfr_pkg::PICC_SEL1 && armed_q)
							state_d = S_CARD;
					end
				end else if (address == rfr_pkg::A_FIFOLEVEL) begin
					if (write_data[7]) count_d = '0;
				end else if (address == rfr_pkg::A_COMMAND) begin
					reg_req.we = 1'b1; reg_req.waddr = address;
					reg_req.wdata = write_data;
					case (write_data)
						rfr_pkg::CMD_SOFTRESET: begin
							armed_d = 1'b0; state_d = S_SOFT;
						end
						rfr_pkg::CMD_TRANSCEIVE: state_d = S_CARD;
						rfr_pkg::CMD_CALC_CRC: begin
							if (count_q == '0) begin
								crc_d = 16'h0000; state_d = S_CRC_WL;
							end else begin
								crc_d = rfr_pkg::CRC_INIT; i_d = '0;
								fifo_req.re = 1'b1; fifo_req.raddr = '0;
								state_d = S_CRC;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end else begin
					reg_req.we = 1'b1; reg_req.waddr = address;
					reg_req.wdata = write_data;
				end
			end
			S_ONE: if (slot_free) begin
				out_ld = 1'b1; out_dat = res_q; state_d = S_IDLE;
			end
			S_RREG: if (slot_free) begin
				out_ld = 1'b1; out_dat = reg_rdata; state_d = S_IDLE;
			end
			S_BURST: if (slot_free) begin
				out_ld = 1'b1; out_dat = fifo_rdata;
				out_lst = (i_q + 1'b1 == n_q);
				if (out_lst) begin
					count_d = '0;
					rmw_addr_d = rfr_pkg::A_COMIRQ; rmw_set_d = 1'b0;
					state_d = S_RMW_RD;
				end else begin
					i_d = i_q + 1'b1;
					fifo_req.re = 1'b1; fifo_req.raddr = FW'(i_q + 1'b1);
				end
			end
			S_RMW_RD: begin
				reg_req.re = 1'b1; reg_req.raddr = rmw_addr_q; state_d = S_RMW_WR;
			end
			S_RMW_WR: begin
				reg_req.we = 1'b1; reg_req.waddr = rmw_addr_q;
				reg_req.wdata = rmw_set_q ? (reg_rdata | rfr_pkg::RX_IRQ)
					: (reg_rdata & ~rfr_pkg::RX_IRQ);
				state_d = S_IDLE;
			end
			S_SOFT: begin
				reg_req.we = 1'b1; reg_req.waddr = rfr_pkg::A_COMIRQ;
				reg_req.wdata = 8'h00; state_d = S_IDLE;
			end
			S_CARD: begin
				state_d = S_IDLE;
				rmw_addr_d = rfr_pkg::A_COMIRQ; rmw_set_d = 1'b1;
				if (count_q != '0) begin
					if (head_q == rfr_pkg::PICC_REQA || head_q == rfr_pkg::PICC_WUPA) begin
						fifo_req.we = 1'b1; fifo_req.waddr = '0;
						fifo_req.wdata = rfr_pkg::ATQA_LO;
						head_d = rfr_pkg::ATQA_LO; state_d = S_REQ2;
					end else if ((head_q == rfr_pkg::PICC_SEL1 ||
						head_q == rfr_pkg::PICC_SEL2 || head_q == rfr_pkg::PICC_SEL3) &&
						armed_q && count_q >= CW'(9)) begin
						fifo_req.re = 1'b1; fifo_req.raddr = FW'(2);
						k_d = '0; match_d = 1'b1; state_d = S_SEL;
					end else if (head_q == rfr_pkg::PICC_SEL1 && !armed_q) begin
						k_d = '0; state_d = S_UID;
					end
				end
			end
			S_REQ2: begin
				fifo_req.we = 1'b1; fifo_req.waddr = FW'(1);
				fifo_req.wdata = rfr_pkg::ATQA_HI;
				count_d = CW'(2); armed_d = 1'b0; state_d = S_RMW_RD;
			end
			S_SEL: begin
				if (k_q == 3'd3) begin
					armed_d = 1'b0;
					if (m) begin
						fifo_req.we = 1'b1; fifo_req.waddr = '0;
						fifo_req.wdata = rfr_pkg::SAK_VALUE;
						head_d = rfr_pkg::SAK_VALUE; state_d = S_SEL1;
					end else begin
						count_d = '0; state_d = S_IDLE;
					end
				end else begin
					match_d = m; k_d = k_q + 1'b1;
					fifo_req.re = 1'b1; fifo_req.raddr = FW'(k_q + 3'd3);
				end
			end
			S_SEL1: begin
				fifo_req.we = 1'b1; fifo_req.waddr = FW'(1);
				fifo_req.wdata = rfr_pkg::CRC_SAK[7:0]; state_d = S_SEL2;
			end
			S_SEL2: begin
				fifo_req.we = 1'b1; fifo_req.waddr = FW'(2);
				fifo_req.wdata = rfr_pkg::CRC_SAK[15:8];
				count_d = CW'(3); state_d = S_RMW_RD;
			end
			S_UID: begin
				fifo_req.we = 1'b1; fifo_req.waddr = FW'(k_q);
				fifo_req.wdata = (k_q == 3'd4) ? uid_x : uid_k;
				if (k_q == 3'd0) head_d = uid_k;
				if (k_q == 3'd4) begin
					count_d = CW'(5); armed_d = 1'b1; state_d = S_RMW_RD;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			S_CRC: begin
				crc_d = rfr_pkg::crc_byte(crc_q, fifo_rdata);
				if (i_q + 1'b1 == count_q) begin
					state_d = S_CRC_WL;
				end else begin
					i_d = i_q + 1'b1;
					fifo_req.re = 1'b1; fifo_req.raddr = FW'(i_q + 1'b1);
				end
			end
			S_CRC_WL: begin
				reg_req.we = 1'b1; reg_req.waddr = rfr_pkg::A_CRC_L;
				reg_req.wdata = crc_q[7:0]; state_d = S_CRC_WH;
			end
			S_CRC_WH: begin
				reg_req.we = 1'b1; reg_req.waddr = rfr_pkg::A_CRC_H;
				reg_req.wdata = crc_q[15:8];
				rmw_addr_d = rfr_pkg::A_DIVIRQ; rmw_set_d = 1'b1;
				state_d = S_RMW_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			armed_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			armed_q <= armed_d;
			if (out_ld) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d; n_q <= n_d; head_q <= head_d; res_q <= res_d;
		k_q <= k_d; match_q <= match_d; crc_q <= crc_d;
		rmw_addr_q <= rmw_addr_d; rmw_set_q <= rmw_set_d;
		if (out_ld) begin
			read_data_q <= out_dat;
			last_q <= out_lst;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign last      = last_q;
	assign status.count = count_q;
	assign status.armed = armed_q;
endmodule
`default_nettype wire

// ===== rtl/rfid_reader_register_file_unit.sv =====
// Timing: a read gives its first byte from a registered output after the transfer,
// and a FIFO burst then gives one byte a cycle while the output is not stalled.
// Only one access is in flight at a time: in_ready is high only while the
// sequencer idles, and an output stall holds the sequencer.
// Reset: arst_n idles the sequencer, clears the FIFO count, the armed flag and
// the register valid bits and loads the reset UID; registers read reset values.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rfid_reader_register_file_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [5:0]  address,
	input  wire logic [7:0]  write_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       read_data,
	output logic             last
);
	logic [31:0] uid_q;
	rfr_pkg::reg_req_t reg_req;
	rfr_pkg::fifo_req_t fifo_req;
	rfr_pkg::status_t status;
	logic [7:0] reg_rdata, fifo_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uid_q <= rfr_pkg::UID_RESET;
		end else if (cfg_we) begin
			uid_q <= cfg_wdata;
		end
	end

	rfr_ctrl u_ctrl (
		.clk, .arst_n, .uid(uid_q),
		.in_valid, .in_ready, .kind, .address, .write_data,
		.out_valid, .out_ready, .read_data, .last,
		.reg_req, .reg_rdata, .fifo_req, .fifo_rdata, .status
	);

	rfr_reg_bank u_regs (.clk, .arst_n, .req(reg_req), .rdata(reg_rdata));

	rfr_fifo_buf u_fifo (.clk, .req(fifo_req), .rdata(fifo_rdata));

	`ASSERT_NEVER(a_count_range, clk, arst_n, 32'(status.count) > rfr_pkg::FIFO_DEPTH)
	`ASSERT_IMPL(a_write_silent, clk, arst_n, (in_valid && in_ready && kind) |=> !$rose(out_valid))
	`ASSERT_IMPL(a_arm_count, clk, arst_n, $rose(status.armed) |-> (32'(status.count) == 5))
	`ASSERT_NEVER(a_mem_busy, clk, arst_n, reg_req.we && reg_req.re)
endmodule
`default_nettype wire

// ===== tb/rfr_tb_pkg.sv =====
`timescale 1ns / 1ps
package rfr_tb_pkg;
	typedef enum logic {
		ACC_READ  = 1'b0,
		ACC_WRITE = 1'b1
	} acc_kind_e;
endpackage

// ===== tb/rfr_checker.sv =====
`timescale 1ns / 1ps
module rfr_checker
	import rfr_pkg::*;
	import rfr_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        kind,
	input  logic [5:0]  address,
	input  logic [7:0]  write_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  read_data,
	input  logic        last,
	output int          errors,
	output int          pending
);
	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} rd_beat_t;

	logic [7:0]  regs [REG_COUNT];
	logic [7:0]  fifo_mem [FIFO_DEPTH];
	int unsigned lvl;
	bit          armed;
	logic [31:0] uid;
	rd_beat_t    rd_beats_q [$];

	assign pending = rd_beats_q.size();

	task automatic report(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		errors++;
	endtask

	function automatic logic [7:0] uid_at(input int k);
		return uid[8*k +: 8];
	endfunction

	task automatic set_lvl(input int unsigned n);
		lvl = n;
		regs[A_FIFOLEVEL] = n[7:0];
	endtask

	function automatic logic [15:0] fifo_crc(input int unsigned n);
		logic [15:0] c;
		c = CRC_INIT;
		for (int i = 0; i < n; i++) begin
			c ^= {8'h00, fifo_mem[i]};
			for (int b = 0; b < 8; b++)
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Emulated card answers a REQA, WUPA or select frame that sits in the FIFO.
	task automatic card_reply();
		logic [7:0]  cmd;
		logic [15:0] c;
		bit          hit;
		if (lvl == 0)
			return;
		cmd = fifo_mem[0];
		if (cmd == PICC_REQA || cmd == PICC_WUPA) begin
			fifo_mem[0] = ATQA_LO;
			fifo_mem[1] = ATQA_HI;
			set_lvl(2);
			regs[A_COMIRQ] |= RX_IRQ;
			armed = 0;
		end else if (cmd == PICC_SEL1 || cmd == PICC_SEL2 || cmd == PICC_SEL3) begin
			if (armed && lvl >= 9) begin
				hit = fifo_mem[2] == uid_at(0) && fifo_mem[3] == uid_at(1) &&
				      fifo_mem[4] == uid_at(2) && fifo_mem[5] == uid_at(3);
				if (hit) begin
					fifo_mem[0] = SAK_VALUE;
					c = fifo_crc(1);
					fifo_mem[1] = c[7:0];
					fifo_mem[2] = c[15:8];
					set_lvl(3);
					regs[A_COMIRQ] |= RX_IRQ;
				end else begin
					set_lvl(0);
				end
				armed = 0;
			end else if (!armed && cmd == PICC_SEL1) begin
				for (int k = 0; k < 4; k++)
					fifo_mem[k] = uid_at(k);
				fifo_mem[4] = uid_at(0) ^ uid_at(1) ^ uid_at(2) ^ uid_at(3);
				set_lvl(5);
				regs[A_COMIRQ] |= RX_IRQ;
				armed = 1;
			end
		end
	endtask

	task automatic model_access(input acc_kind_e k, input logic [5:0] a, input logic [7:0] d);
		int unsigned n;
		logic [15:0] c;
		rd_beat_t    beat;
		if (k == ACC_READ) begin
			if (a == A_FIFODATA && lvl > 0) begin
				n = (lvl > BURST_MAX) ? BURST_MAX : lvl;
				for (int i = 0; i < n; i++) begin
					beat.data = fifo_mem[i];
					beat.fin  = (i + 1 == n);
					rd_beats_q.push_back(beat);
				end
				set_lvl(0);
				regs[A_COMIRQ] &= ~RX_IRQ;
				return;
			end
			if (a == A_VERSION)
				beat.data = VERSION_VALUE;
			else if (a == A_FIFOLEVEL)
				beat.data = lvl[7:0];
			else if (a == A_FIFODATA)
				beat.data = 8'h00;
			else
				beat.data = regs[a];
			beat.fin = 1'b1;
			rd_beats_q.push_back(beat);
			return;
		end
		if (a == A_FIFODATA) begin
			if (lvl < FIFO_DEPTH) begin
				fifo_mem[lvl] = d;
				set_lvl(lvl + 1);
				if (fifo_mem[0] == PICC_SEL1 && armed && lvl == 9)
					card_reply();
			end
		end else if (a == A_FIFOLEVEL) begin
			if (d[7])
				lvl = 0;
			regs[A_FIFOLEVEL] = d & LEVEL_MASK;
		end else if (a == A_COMMAND) begin
			if (d == CMD_SOFTRESET) begin
				armed = 0;
				regs[A_COMIRQ] = 8'h00;
			end else if (d == CMD_TRANSCEIVE) begin
				card_reply();
			end else if (d == CMD_CALC_CRC) begin
				c = (lvl == 0) ? 16'h0000 : fifo_crc(lvl);
				regs[A_CRC_L] = c[7:0];
				regs[A_CRC_H] = c[15:8];
				regs[A_DIVIRQ] |= 8'h04;
			end
			regs[A_COMMAND] = d;
		end else begin
			regs[a] = d;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rd_beat_t want;
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++)
				regs[i] = 8'h00;
			regs[A_CONTROL] = CONTROL_RESET;
			regs[A_VERSION] = VERSION_VALUE;
			lvl   = 0;
			armed = 0;
			uid   = UID_RESET;
			rd_beats_q.delete();
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (rd_beats_q.size() == 0) begin
					report($sformatf("unexpected read byte %02h last %0b", read_data, last));
				end else begin
					want = rd_beats_q.pop_front();
					if (read_data !== want.data)
						report($sformatf("read_data %02h, want %02h", read_data, want.data));
					if (last !== want.fin)
						report($sformatf("last %0b, want %0b", last, want.fin));
				end
			end
			if (cfg_we)
				uid = cfg_wdata;
			if (in_valid && in_ready)
				model_access(acc_kind_e'(kind), address, write_data);
		end
	end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import rfr_pkg::*;
	import rfr_tb_pkg::*;

	localparam int STALL_LIMIT = 3000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        kind;
	logic [5:0]  address;
	logic [7:0]  write_data;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  read_data;
	logic        last;
	int          errors;
	int          pending;

	int          send_idle;
	int          recv_idle;
	int          accesses;
	int          quiet_cycles;
	logic [31:0] cur_uid;

	rfid_reader_register_file_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.address    (address),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.last       (last)
	);

	rfr_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.address    (address),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.last       (last),
		.errors     (errors),
		.pending    (pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Called right after a rising edge; returns on the edge of the transfer.
	task automatic access(input acc_kind_e k, input logic [5:0] a, input logic [7:0] d);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		address    <= a;
		write_data <= d;
		forever begin
			@(negedge clk);
			if (in_ready) begin
				@(posedge clk);
				break;
			end
			@(posedge clk);
		end
		accesses++;
	endtask

	task automatic push(input logic [7:0] d);
		access(ACC_WRITE, A_FIFODATA, d);
	endtask

	task automatic flush();
		access(ACC_WRITE, A_FIFOLEVEL, 8'h80 | 8'($urandom_range(127)));
	endtask

	task automatic command(input logic [7:0] c);
		access(ACC_WRITE, A_COMMAND, c);
	endtask

	task automatic read_reg(input logic [5:0] a);
		access(ACC_READ, a, 8'($urandom));
	endtask

	// Hold until the block is idle, then load a new card UID.
	task automatic load_uid(input logic [31:0] v);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (100) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		cur_uid   = v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic select_frame(input logic [7:0] sel, input bit good);
		logic [7:0] bcc;
		bcc = cur_uid[7:0] ^ cur_uid[15:8] ^ cur_uid[23:16] ^ cur_uid[31:24];
		flush();
		push(sel);
		push(8'h70);
		for (int k = 0; k < 4; k++)
			push(good ? cur_uid[8*k +: 8] : 8'($urandom));
		push(bcc);
		push(8'($urandom));
		push(8'($urandom));
		if (sel != PICC_SEL1 || $urandom_range(3) == 0)
			command(CMD_TRANSCEIVE);
		read_reg(A_FIFODATA);
	endtask

	task automatic random_frame();
		int n;
		case ($urandom_range(7))
			0: begin
				flush();
				push($urandom_range(1) ? PICC_REQA : PICC_WUPA);
				command(CMD_TRANSCEIVE);
				read_reg(A_FIFODATA);
			end
			1, 2: begin
				flush();
				push(PICC_SEL1);
				push(8'h20);
				command(CMD_TRANSCEIVE);
				read_reg(A_FIFODATA);
				if ($urandom_range(1))
					select_frame(PICC_SEL1 + 8'(2 * $urandom_range(2)),
						$urandom_range(3) != 0);
			end
			3: begin
				flush();
				n = ($urandom_range(9) == 0) ? $urandom_range(FIFO_DEPTH + 2) :
					$urandom_range(6);
				for (int i = 0; i < n; i++)
					push(8'($urandom));
				command(CMD_CALC_CRC);
				read_reg(A_CRC_L);
				read_reg(A_CRC_H);
				read_reg(A_DIVIRQ);
				read_reg(A_FIFODATA);
			end
			4: begin
				n = $urandom_range(4);
				for (int i = 0; i < n; i++)
					push(8'($urandom));
				read_reg($urandom_range(1) ? A_FIFOLEVEL : A_FIFODATA);
			end
			5: command($urandom_range(1) ? 8'($urandom) :
				($urandom_range(1) ? CMD_SOFTRESET : CMD_TRANSCEIVE));
			default: access(acc_kind_e'($urandom_range(1)), 6'($urandom), 8'($urandom));
		endcase
	endtask

	task automatic random_phase(input int count);
		int goal;
		goal = accesses + count;
		while (accesses < goal)
			random_frame();
	endtask

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = 32'h0;
		in_valid   = 1'b0;
		kind       = ACC_READ;
		address    = 6'h0;
		write_data = 8'h0;
		out_ready  = 1'b0;
		accesses   = 0;
		quiet_cycles = 0;
		cur_uid    = UID_RESET;
		send_idle  = 36;
		recv_idle  = 58;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset values, special addresses, card exchange, full FIFO.
		read_reg(A_VERSION);
		read_reg(A_CONTROL);
		read_reg(A_FIFOLEVEL);
		read_reg(A_FIFODATA);
		access(ACC_WRITE, 6'h3F, 8'hFF);
		read_reg(6'h3F);
		access(ACC_WRITE, A_FIFOLEVEL, 8'h7F);
		read_reg(A_FIFOLEVEL);
		push(PICC_REQA);
		command(CMD_TRANSCEIVE);
		read_reg(A_COMIRQ);
		read_reg(A_FIFODATA);
		command(CMD_CALC_CRC);
		read_reg(A_CRC_L);
		push(PICC_SEL1);
		command(CMD_TRANSCEIVE);
		read_reg(A_FIFODATA);
		select_frame(PICC_SEL1, 1);
		command(CMD_SOFTRESET);
		for (int i = 0; i < FIFO_DEPTH + 2; i++)
			push(8'(i * 37));
		read_reg(A_FIFOLEVEL);
		read_reg(A_FIFODATA);
		random_phase(30);

		load_uid(32'hFFFF_FFFF);
		send_idle = 58;
		recv_idle = 36;
		random_phase(40);

		load_uid(32'h0000_0000);
		send_idle = 0;
		recv_idle = 0;
		random_phase(25);

		load_uid($urandom);
		random_phase(25);

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rfr_pkg.sv
rtl/rfr_reg_bank.sv
rtl/rfr_fifo_buf.sv
rtl/rfr_ctrl.sv
rtl/rfid_reader_register_file_unit.sv
tb/rfr_tb_pkg.sv
tb/rfr_checker.sv
tb/tb_top.sv
